// File: src/sha1h_pkg.sv
// Shared types and constants for the SHA-1 message hasher.
`default_nettype none
package sha1h_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       end_of_message;
  } in_word_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic        last_word;
  } out_word_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROUND,
    ST_FOLD,
    ST_PAD,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic       init;
    logic       shift_en;
    logic [7:0] shift_byte;
    logic       step;
    logic       fold;
    logic [6:0] rnd;
  } core_ctrl_t;

  localparam logic [31:0] K_R0 = 32'h5A827999;
  localparam logic [31:0] K_R1 = 32'h6ED9EBA1;
  localparam logic [31:0] K_R2 = 32'h8F1BBCDC;
  localparam logic [31:0] K_R3 = 32'hCA62C1D6;

  localparam logic [4:0][31:0] H_INIT = {
    32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
  };

  localparam logic [7:0] PAD_MARK   = 8'h80;
  localparam logic [6:0] LAST_ROUND = 7'd79;
  localparam logic [5:0] LAST_POS   = 6'd63;
  localparam logic [5:0] LEN_POS    = 6'd56;
  localparam logic [2:0] LAST_WORD  = 3'd4;

endpackage
`default_nettype wire

// File: src/sha1h_core.sv
// Round unit, message schedule window and chaining words of the hasher.
`default_nettype none
module sha1h_core (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire sha1h_pkg::core_ctrl_t ctrl_i,
  output logic [4:0][31:0]       h_o
);

  logic [511:0]      blk_q, blk_d;
  logic [4:0][31:0]  h_q, h_d;
  logic [4:0][31:0]  v_q, v_d;
  logic [31:0]       a, b, c, d, e;
  logic [31:0]       w0, w2, w8, w13, wx, wnew;
  logic [31:0]       f, k, t;

  assign a = v_q[0];
  assign b = v_q[1];
  assign c = v_q[2];
  assign d = v_q[3];
  assign e = v_q[4];

  assign w0   = blk_q[511:480];
  assign w2   = blk_q[447:416];
  assign w8   = blk_q[255:224];
  assign w13  = blk_q[95:64];
  assign wx   = w13 ^ w8 ^ w2 ^ w0;
  assign wnew = {wx[30:0], wx[31]};

  always_comb begin
    if (ctrl_i.rnd < 7'd20) begin
      f = (b & c) | (~b & d);
      k = sha1h_pkg::K_R0;
    end else if (ctrl_i.rnd < 7'd40) begin
      f = b ^ c ^ d;
      k = sha1h_pkg::K_R1;
    end else if (ctrl_i.rnd < 7'd60) begin
      f = (b & c) | (b & d) | (c & d);
      k = sha1h_pkg::K_R2;
    end else begin
      f = b ^ c ^ d;
      k = sha1h_pkg::K_R3;
    end
  end

  assign t = {a[26:0], a[31:27]} + f + e + k + w0;

  always_comb begin
    blk_d = blk_q;
    h_d   = h_q;
    v_d   = v_q;
    if (ctrl_i.init) begin
      h_d = sha1h_pkg::H_INIT;
      v_d = sha1h_pkg::H_INIT;
    end else if (ctrl_i.fold) begin
      for (int i = 0; i < 5; i++) begin
        h_d[i] = h_q[i] + v_q[i];
        v_d[i] = h_q[i] + v_q[i];
      end
    end else if (ctrl_i.step) begin
      v_d   = {d, c, {b[1:0], b[31:2]}, a, t};
      blk_d = {blk_q[479:0], wnew};
    end
    if (ctrl_i.shift_en) begin
      blk_d = {blk_q[503:0], ctrl_i.shift_byte};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h_q <= sha1h_pkg::H_INIT;
      v_q <= sha1h_pkg::H_INIT;
    end else begin
      h_q <= h_d;
      v_q <= v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    blk_q <= blk_d;
  end

  assign h_o = h_q;

endmodule
`default_nettype wire

// File: src/sha1_message_hasher.sv
// Top level of the streaming SHA-1 message hasher: sequencer, padding and digest output.
// Message bytes are taken one per cycle while idle. The 64th byte of a block starts the
// compression: 80 rounds on the single round unit at one round per cycle, then a fold
// into the chaining words, with the input stalled throughout. The end-of-message word
// then shifts the padding and the length into the block one byte per cycle, runs one
// more compression, or two when the marker byte lands past position 55, and offers
// the digest as five words, H0 first, the fifth with last_word set.
// The input is stalled from the end-of-message word until the fifth digest word
// is taken; the hasher is then back at its initial state for the next message.
`default_nettype none
module sha1_message_hasher (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   in_valid_i,
  output logic                  in_stall_o,
  input  wire sha1h_pkg::in_word_t in_i,
  output logic                  out_valid_o,
  input  wire                   out_stall_i,
  output sha1h_pkg::out_word_t  out_o
);

  sha1h_pkg::state_e     state_q, state_d;
  sha1h_pkg::core_ctrl_t ctrl;
  logic [5:0]            fill_q, fill_d;
  logic [60:0]           total_q, total_d;
  logic                  fin_q, fin_d;
  logic                  sent_q, sent_d;
  logic                  lenb_q, lenb_d;
  logic [6:0]            rnd_q, rnd_d;
  logic [2:0]            oidx_q, oidx_d;
  logic [4:0][31:0]      h;
  logic [63:0]           len_bits;
  logic [7:0]            pad_byte;
  logic                  in_take;

  sha1h_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (ctrl),
    .h_o    (h)
  );

  assign len_bits = {total_q, 3'b000};
  assign in_take  = in_valid_i && !in_stall_o;

  always_comb begin
    if (!sent_q) begin
      pad_byte = sha1h_pkg::PAD_MARK;
    end else if (lenb_q && fill_q >= sha1h_pkg::LEN_POS) begin
      pad_byte = len_bits[{~fill_q[2:0], 3'b000} +: 8];
    end else begin
      pad_byte = 8'h00;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      sha1h_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          if (in_i.byte_valid && fill_q == sha1h_pkg::LAST_POS) begin
            state_d = sha1h_pkg::ST_ROUND;
          end else if (in_i.end_of_message) begin
            state_d = sha1h_pkg::ST_PAD;
          end
        end
      end
      sha1h_pkg::ST_ROUND: begin
        if (rnd_q == sha1h_pkg::LAST_ROUND) begin
          state_d = sha1h_pkg::ST_FOLD;
        end
      end
      sha1h_pkg::ST_FOLD: begin
        if (!fin_q) begin
          state_d = sha1h_pkg::ST_IDLE;
        end else if (lenb_q) begin
          state_d = sha1h_pkg::ST_OUT;
        end else begin
          state_d = sha1h_pkg::ST_PAD;
        end
      end
      sha1h_pkg::ST_PAD: begin
        if (fill_q == sha1h_pkg::LAST_POS) begin
          state_d = sha1h_pkg::ST_ROUND;
        end
      end
      sha1h_pkg::ST_OUT: begin
        if (!out_stall_i && oidx_q == sha1h_pkg::LAST_WORD) begin
          state_d = sha1h_pkg::ST_IDLE;
        end
      end
      default: state_d = sha1h_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o        = (state_q != sha1h_pkg::ST_IDLE);
    out_valid_o       = (state_q == sha1h_pkg::ST_OUT);
    out_o.digest_word = h[oidx_q];
    out_o.last_word   = (oidx_q == sha1h_pkg::LAST_WORD);

    ctrl    = '0;
    ctrl.rnd = rnd_q;
    fill_d  = fill_q;
    total_d = total_q;
    fin_d   = fin_q;
    sent_d  = sent_q;
    lenb_d  = lenb_q;
    rnd_d   = rnd_q;
    oidx_d  = oidx_q;

    case (state_q)
      sha1h_pkg::ST_IDLE: begin
        if (in_take) begin
          if (in_i.byte_valid) begin
            ctrl.shift_en   = 1'b1;
            ctrl.shift_byte = in_i.data_byte;
            fill_d          = fill_q + 6'd1;
            total_d         = total_q + 61'd1;
          end
          if (in_i.end_of_message) begin
            fin_d = 1'b1;
          end
        end
      end
      sha1h_pkg::ST_ROUND: begin
        ctrl.step = 1'b1;
        rnd_d     = (rnd_q == sha1h_pkg::LAST_ROUND) ? 7'd0 : rnd_q + 7'd1;
      end
      sha1h_pkg::ST_FOLD: begin
        ctrl.fold = 1'b1;
        if (fin_q && !lenb_q && sent_q) begin
          lenb_d = 1'b1;
        end
      end
      sha1h_pkg::ST_PAD: begin
        ctrl.shift_en   = 1'b1;
        ctrl.shift_byte = pad_byte;
        fill_d          = fill_q + 6'd1;
        if (!sent_q) begin
          sent_d = 1'b1;
          if (fill_q < sha1h_pkg::LEN_POS) begin
            lenb_d = 1'b1;
          end
        end
      end
      sha1h_pkg::ST_OUT: begin
        if (!out_stall_i) begin
          if (oidx_q == sha1h_pkg::LAST_WORD) begin
            oidx_d    = 3'd0;
            ctrl.init = 1'b1;
            fill_d    = 6'd0;
            total_d   = 61'd0;
            fin_d     = 1'b0;
            sent_d    = 1'b0;
            lenb_d    = 1'b0;
          end else begin
            oidx_d = oidx_q + 3'd1;
          end
        end
      end
      default: begin
        fin_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sha1h_pkg::ST_IDLE;
      fill_q  <= 6'd0;
      total_q <= 61'd0;
      fin_q   <= 1'b0;
      sent_q  <= 1'b0;
      lenb_q  <= 1'b0;
      rnd_q   <= 7'd0;
      oidx_q  <= 3'd0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      total_q <= total_d;
      fin_q   <= fin_d;
      sent_q  <= sent_d;
      lenb_q  <= lenb_d;
      rnd_q   <= rnd_d;
      oidx_q  <= oidx_d;
    end
  end

endmodule
`default_nettype wire
